// File: rtl/nelw_pkg.sv
// ----------------------------------------------------------------------------
// nelw_pkg
// shared types and constants for the nongraphic escape line wrapper
// ----------------------------------------------------------------------------
package nelw_pkg;

  localparam logic [7:0] LF_CHAR       = 8'h0A;
  localparam logic [7:0] PRINT_LO      = 8'h20;
  localparam logic [7:0] PRINT_HI      = 8'h7E;
  localparam logic [7:0] ESCAPE_LEN    = 8'd11;
  localparam logic [7:0] WIDTH_RESET   = 8'd80;

  // classified request passed from front to back
  typedef struct packed {
    logic [7:0] data;       // raw byte
    logic       wrap;       // line feed goes out before the text
    logic       printable;  // byte passes through as is
  } nelw_cmd_t;

endpackage

// File: rtl/nelw_front.sv
// ----------------------------------------------------------------------------
// nelw_front
// accepts input bytes, classifies them and tracks the output column
// ----------------------------------------------------------------------------
module nelw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output nelw_pkg::nelw_cmd_t q_wdata
);
  import nelw_pkg::*;

  logic [7:0] line_width_r;
  logic [7:0] column_r;
  logic [7:0] column_nxt;
  logic       printable;
  logic [7:0] cost;
  logic [8:0] sum;
  logic       wrap;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  assign printable = (in_tdata >= PRINT_LO) && (in_tdata <= PRINT_HI);
  assign cost      = printable ? 8'd1 : ESCAPE_LEN;
  assign sum       = {1'b0, column_r} + {1'b0, cost};
  assign wrap      = sum >= {1'b0, line_width_r};

  always_comb begin
    column_nxt = wrap ? cost : sum[7:0];
    // newline escape is closed by a line feed
    if (!printable && (in_tdata == LF_CHAR)) begin
      column_nxt = '0;
    end
  end

  assign q_wdata = '{data: in_tdata, wrap: wrap, printable: printable};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WIDTH_RESET;
      column_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_width_r <= cfg_data;
      end
      if (q_push) begin
        column_r <= column_nxt;
      end
    end
  end

endmodule

// File: rtl/nelw_fifo.sv
// ----------------------------------------------------------------------------
// nelw_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
module nelw_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nelw_pkg::nelw_cmd_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output nelw_pkg::nelw_cmd_t rdata
);
  import nelw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  nelw_cmd_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = count_r == FULL_CNT;
  assign empty = count_r == '0;
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/nelw_back.sv
// ----------------------------------------------------------------------------
// nelw_back
// expands queued requests into output characters, one per cycle while out_tready is high
// ----------------------------------------------------------------------------
module nelw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  nelw_pkg::nelw_cmd_t q_rdata,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  import nelw_pkg::*;

  // character positions within one run
  localparam logic [3:0] STEP_WRAP  = 4'd0;
  localparam logic [3:0] STEP_OPEN  = 4'd1;
  localparam logic [3:0] STEP_Z0    = 4'd2;
  localparam logic [3:0] STEP_X     = 4'd3;
  localparam logic [3:0] STEP_HEXH  = 4'd4;
  localparam logic [3:0] STEP_HEXL  = 4'd5;
  localparam logic [3:0] STEP_BAR   = 4'd6;
  localparam logic [3:0] STEP_Z1    = 4'd7;
  localparam logic [3:0] STEP_OCT2  = 4'd8;
  localparam logic [3:0] STEP_OCT1  = 4'd9;
  localparam logic [3:0] STEP_OCT0  = 4'd10;
  localparam logic [3:0] STEP_CLOSE = 4'd11;
  localparam logic [3:0] STEP_LF    = 4'd12;

  logic [3:0] step_r;
  logic [3:0] cur;
  logic       load;
  logic       fire;
  logic       last;
  logic [7:0] ch;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
  endfunction

  assign load  = !out_valid_r || out_tready;
  assign fire  = load && !q_empty;
  assign cur   = ((step_r == STEP_WRAP) && !q_rdata.wrap) ? STEP_OPEN : step_r;

  always_comb begin
    if (q_rdata.printable) begin
      last = cur == STEP_OPEN;
    end else if (q_rdata.data == LF_CHAR) begin
      last = cur == STEP_LF;
    end else begin
      last = cur == STEP_CLOSE;
    end
  end

  always_comb begin
    case (cur)
      STEP_WRAP:  ch = LF_CHAR;
      STEP_OPEN:  ch = q_rdata.printable ? q_rdata.data : 8'h5B;
      STEP_Z0:    ch = 8'h30;
      STEP_X:     ch = 8'h78;
      STEP_HEXH:  ch = hex_char(q_rdata.data[7:4]);
      STEP_HEXL:  ch = hex_char(q_rdata.data[3:0]);
      STEP_BAR:   ch = 8'h7C;
      STEP_Z1:    ch = 8'h30;
      STEP_OCT2:  ch = 8'h30 + {6'h0, q_rdata.data[7:6]};
      STEP_OCT1:  ch = 8'h30 + {5'h0, q_rdata.data[5:3]};
      STEP_OCT0:  ch = 8'h30 + {5'h0, q_rdata.data[2:0]};
      STEP_CLOSE: ch = 8'h5D;
      STEP_LF:    ch = LF_CHAR;
      default:    ch = LF_CHAR;
    endcase
  end

  assign q_pop      = fire && last;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= ch;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_WRAP;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= !q_empty;
      end
      if (fire) begin
        step_r <= last ? STEP_WRAP : cur + 4'd1;
      end
    end
  end

endmodule

// File: rtl/nongraphic_escape_line_wrapper.sv
// ----------------------------------------------------------------------------
// nongraphic_escape_line_wrapper
// byte stream to printable text with escapes and line wrapping
// ----------------------------------------------------------------------------
// Each input byte turns into a run of output characters. Printable bytes
// (0x20 to 0x7e) pass through as one character; every other byte becomes
// the 11-character text [0xhh|0ooo] in lowercase hex and octal. When the
// column plus the cost of the byte reaches line_width, a line feed comes
// first and the column restarts at that cost; a newline byte's escape is
// followed by a line feed and the column returns to zero. A run is one to
// thirteen characters (1 or 2 for a plain byte, 11 to 13 for an escape),
// tlast marks its end. The output side moves one character per cycle
// while out_tready is high; the character sequencer in the back end steps
// through each run. The front end accepts a byte per cycle into a request
// queue of FIFO_DEPTH entries while that queue is not full, so input bytes
// keep flowing while a long escape drains. line_width is written through
// the cfg port (always ready) and must only be changed while idle.
// ----------------------------------------------------------------------------
module nongraphic_escape_line_wrapper #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // input byte stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  // output character stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,   // last_of_run
  // line width register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data     // [7:0] line_width
);
  import nelw_pkg::*;

  // request queue handshake
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  nelw_cmd_t q_wdata;
  nelw_cmd_t q_rdata;

  // front: classify, column tracking, wrap decision, config register
  nelw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // decouples byte intake from character output
  nelw_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: character sequencer with registered output
  nelw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
